// File: hdl/fss_pkg.sv
`timescale 1ns / 1ps

package fss_pkg;

  typedef struct packed {
    logic [7:0] name_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic [6:0] match_score;
  } out_item_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_QUERY_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_CHARS_LO      = 3'd1;
  localparam logic [2:0] CFG_CHARS_MID_LO  = 3'd2;
  localparam logic [2:0] CFG_CHARS_MID_HI  = 3'd3;
  localparam logic [2:0] CFG_CHARS_HI      = 3'd4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned QLEN_W      = 6;
  localparam int unsigned QUERY_MAX   = 32;
  localparam int unsigned QUERY_BITS  = QUERY_MAX * 8;

  localparam logic [QLEN_W-1:0] QUERY_MAX_LEN = QLEN_W'(QUERY_MAX);
  localparam logic [6:0]        PENALTY_CAP   = 7'd101;
  localparam logic [6:0]        FULL_SCORE    = 7'd100;

  // ASCII lowercase fold; only A..Z change
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

// File: hdl/fss_cfg_regs.sv
`timescale 1ns / 1ps

module fss_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [fss_pkg::CFG_INDEX_W-1:0]     wr_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]      wr_data,
  output logic [fss_pkg::QLEN_W-1:0]          active_len,
  output logic [fss_pkg::QUERY_BITS-1:0]      query_bits
);

  logic [fss_pkg::QLEN_W-1:0]     query_length;
  logic [fss_pkg::CFG_DATA_W-1:0] words [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
      words[0]     <= '0;
      words[1]     <= '0;
      words[2]     <= '0;
      words[3]     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        fss_pkg::CFG_QUERY_LENGTH: query_length <= wr_data[fss_pkg::QLEN_W-1:0];
        fss_pkg::CFG_CHARS_LO:     words[0] <= wr_data;
        fss_pkg::CFG_CHARS_MID_LO: words[1] <= wr_data;
        fss_pkg::CFG_CHARS_MID_HI: words[2] <= wr_data;
        fss_pkg::CFG_CHARS_HI:     words[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // lengths past the query store clamp to its size
  assign active_len = (query_length > fss_pkg::QUERY_MAX_LEN) ?
                      fss_pkg::QUERY_MAX_LEN : query_length;
  assign query_bits = {words[3], words[2], words[1], words[0]};

endmodule

// File: hdl/fss_match_core.sv
`timescale 1ns / 1ps

module fss_match_core #(
  parameter int unsigned NAME_MAX = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  fss_pkg::in_item_t              item,
  input  logic [fss_pkg::QLEN_W-1:0]     active_len,
  input  logic [fss_pkg::QUERY_BITS-1:0] query_bits,
  output fss_pkg::out_item_t             result
);

  localparam int unsigned PW = $clog2(NAME_MAX + 1);
  localparam int unsigned SW = PW + 2;
  localparam logic [PW-1:0] POS_MAX = PW'(NAME_MAX);

  logic [PW-1:0]              name_position, name_position_next;
  logic [PW-1:0]              expected_position, expected_position_next;
  logic [fss_pkg::QLEN_W-1:0] query_index, query_index_next;
  logic [6:0]                 penalty_sum, penalty_sum_next;

  logic [7:0]    qchar;
  logic          hit;
  logic [PW-1:0] gap;
  logic [SW-1:0] sum;
  logic          ok;

  always_comb begin
    qchar = query_bits[8*query_index[4:0] +: 8];
    hit   = (query_index < active_len) &&
            (fss_pkg::fold_case(qchar) == fss_pkg::fold_case(item.name_char));
    gap   = (name_position > expected_position) ?
            (name_position - expected_position) : '0;
    sum   = SW'(penalty_sum) + SW'(gap) + SW'(qchar != item.name_char);

    penalty_sum_next       = penalty_sum;
    expected_position_next = expected_position;
    query_index_next       = query_index;
    if (hit) begin
      penalty_sum_next       = (sum > SW'(fss_pkg::PENALTY_CAP)) ?
                               fss_pkg::PENALTY_CAP : sum[6:0];
      expected_position_next = (name_position == POS_MAX) ?
                               POS_MAX : name_position + 1'b1;
      query_index_next       = query_index + 1'b1;
    end
    name_position_next = (name_position == POS_MAX) ? POS_MAX : name_position + 1'b1;

    ok = (query_index_next >= active_len) && (penalty_sum_next <= fss_pkg::FULL_SCORE);
    result.matched     = ok;
    result.match_score = (ok && active_len != '0) ?
                         (fss_pkg::FULL_SCORE - penalty_sum_next) : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_position     <= '0;
      expected_position <= '0;
      query_index       <= '0;
      penalty_sum       <= '0;
    end else if (step) begin
      if (item.last_char) begin
        name_position     <= '0;
        expected_position <= '0;
        query_index       <= '0;
        penalty_sum       <= '0;
      end else begin
        name_position     <= name_position_next;
        expected_position <= expected_position_next;
        query_index       <= query_index_next;
        penalty_sum       <= penalty_sum_next;
      end
    end
  end

endmodule

// File: hdl/fuzzy_subsequence_scorer.sv
`timescale 1ns / 1ps

// Fuzzy subsequence scorer: a file name streams in one byte per beat on the
// in channel (in_valid / in_stall, payload in_item); the beat with last_char
// set closes the name and yields one result beat on the out channel
// (out_valid / out_stall, payload out_item: matched, match_score).
// The query (length and up to 32 chars) is loaded through the cfg write
// port (cfg_valid / cfg_ready, cfg_index, cfg_data); cfg_ready is always
// high. Write it only while no name is in flight.
// Throughput: one byte per cycle while in_stall is low, set by the state
// update in the match core. The last byte is taken into the input
// register, and its result into the result register, which drives out_*.
// Stall: out_stall holds the result register; non-final bytes keep flowing
// into the core, and only a final byte waits in the input register while a
// previous result is still unclaimed, which then raises in_stall.
// Reset (rst, synchronous): clears the query to empty, all per-name state,
// and both valid flags.
module fuzzy_subsequence_scorer #(
  parameter int unsigned NAME_MAX = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fss_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fss_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                           s1_valid;
  fss_pkg::in_item_t              s1_item;
  logic                           go;
  logic                           accept;
  logic [fss_pkg::QLEN_W-1:0]     active_len;
  logic [fss_pkg::QUERY_BITS-1:0] query_bits;
  fss_pkg::out_item_t             result;

  assign cfg_ready = 1'b1;

  fss_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cfg_valid),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .active_len (active_len),
    .query_bits (query_bits)
  );

  // a final byte may only advance when the result register can take it
  assign go       = s1_valid && (!s1_item.last_char || !out_valid || !out_stall);
  assign in_stall = s1_valid && !go;
  assign accept   = in_valid && !in_stall;

  fss_match_core #(
    .NAME_MAX (NAME_MAX)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (go),
    .item       (s1_item),
    .active_len (active_len),
    .query_bits (query_bits),
    .result     (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && s1_item.last_char) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_item.last_char) begin
      out_item <= result;
    end
  end

endmodule
